// File: rtl/core/frame_rms_db_level_meter_unit_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the frame RMS level meter
// Shared concurrent assertion forms. Each one is clocked on the rising edge
// and is switched off while the asynchronous reset is held.
// ----------------------------------------------------------------------------
`ifndef FRAME_RMS_DB_LEVEL_METER_UNIT_DEFINES_SVH
`define FRAME_RMS_DB_LEVEL_METER_UNIT_DEFINES_SVH

// The property holds at every clock edge outside reset.
`define FRDB_ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error(msg);

// The consequent holds in the same cycle as the antecedent.
`define FRDB_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define FRDB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/core/frdb_pkg.sv
// ----------------------------------------------------------------------------
// Frame RMS level meter package
// Constants, control word and status types, and the microcode program that
// computes the frame level from the sum of squares and the sample count.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package frdb_pkg;

	// Fixed widths of the stream fields.
	localparam int SAMPLE_W = 16;
	localparam int LEVEL_W  = 16;

	// Logarithm arithmetic: Q1.31 mantissa, 24 fraction bits of log2.
	localparam int MANT_W      = 32;
	localparam int SQ_W        = 2 * MANT_W;
	localparam int LOG_FRAC_W  = 24;
	localparam int ITER_W      = 5;
	localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(LOG_FRAC_W - 1);

	// round(2560 * log10(2) * 2^16): turns log2 with 24 fraction bits into
	// 1/256 dB with 40 fraction bits.
	localparam int K_W = 27;
	localparam logic signed [K_W-1:0] DB_SCALE_K = 27'sd50504453;
	localparam int ROUND_SHIFT = 40;

	// Level reported for a frame of all-zero samples (-100 dB).
	localparam logic signed [LEVEL_W-1:0] LEVEL_SILENT = -16'sd25600;

	// Datapath operations.
	localparam int OP_W = 4;
	localparam logic [OP_W-1:0] OP_NOP    = 4'd0;
	localparam logic [OP_W-1:0] OP_LD_SUM = 4'd1;
	localparam logic [OP_W-1:0] OP_NORM   = 4'd2;
	localparam logic [OP_W-1:0] OP_MANT   = 4'd3;
	localparam logic [OP_W-1:0] OP_SQUARE = 4'd4;
	localparam logic [OP_W-1:0] OP_FOLD   = 4'd5;
	localparam logic [OP_W-1:0] OP_SAVE   = 4'd6;
	localparam logic [OP_W-1:0] OP_LD_CNT = 4'd7;
	localparam logic [OP_W-1:0] OP_DIFF   = 4'd8;
	localparam logic [OP_W-1:0] OP_MUL    = 4'd9;
	localparam logic [OP_W-1:0] OP_ABS    = 4'd10;
	localparam logic [OP_W-1:0] OP_ROUND  = 4'd11;
	localparam logic [OP_W-1:0] OP_SILENT = 4'd12;
	localparam logic [OP_W-1:0] OP_PUSH   = 4'd13;

	// Jump conditions.
	localparam int COND_W = 3;
	localparam logic [COND_W-1:0] CND_NEVER       = 3'd0;
	localparam logic [COND_W-1:0] CND_ALWAYS      = 3'd1;
	localparam logic [COND_W-1:0] CND_IDLE        = 3'd2;
	localparam logic [COND_W-1:0] CND_SUM_ZERO    = 3'd3;
	localparam logic [COND_W-1:0] CND_NOT_NORMED  = 3'd4;
	localparam logic [COND_W-1:0] CND_ITER_MORE   = 3'd5;
	localparam logic [COND_W-1:0] CND_SECOND_PASS = 3'd6;
	localparam logic [COND_W-1:0] CND_OUT_FREE    = 3'd7;

	// Program addresses.
	localparam int PC_W = 4;
	localparam logic [PC_W-1:0] PC_IDLE   = 4'd0;
	localparam logic [PC_W-1:0] PC_LD_SUM = 4'd1;
	localparam logic [PC_W-1:0] PC_NORM   = 4'd2;
	localparam logic [PC_W-1:0] PC_MANT   = 4'd3;
	localparam logic [PC_W-1:0] PC_SQUARE = 4'd4;
	localparam logic [PC_W-1:0] PC_FOLD   = 4'd5;
	localparam logic [PC_W-1:0] PC_SAVE   = 4'd6;
	localparam logic [PC_W-1:0] PC_LD_CNT = 4'd7;
	localparam logic [PC_W-1:0] PC_DIFF   = 4'd8;
	localparam logic [PC_W-1:0] PC_MUL    = 4'd9;
	localparam logic [PC_W-1:0] PC_ABS    = 4'd10;
	localparam logic [PC_W-1:0] PC_ROUND  = 4'd11;
	localparam logic [PC_W-1:0] PC_SILENT = 4'd12;
	localparam logic [PC_W-1:0] PC_PUSH   = 4'd13;
	localparam logic [PC_W-1:0] PC_WAIT   = 4'd14;

	// One control word: the operation, and a jump taken when cond holds.
	typedef struct packed {
		logic [OP_W-1:0]   op;
		logic [COND_W-1:0] cond;
		logic [PC_W-1:0]   target;
	} ctrl_t;

	// Flags the datapath reports to the sequencer.
	typedef struct packed {
		logic sum_zero;
		logic top_set;
		logic iter_more;
		logic second_pass;
	} dp_stat_t;

	// Everything the sequencer tests in its jump conditions.
	typedef struct packed {
		logic     go;
		logic     out_full;
		dp_stat_t dp;
	} seq_stat_t;

	// Microcode program. The log2 subroutine at NORM..SAVE runs twice, first
	// on the sum of squares and then on the sample count.
	function automatic ctrl_t ucode_rom(input logic [PC_W-1:0] pc);
		ctrl_t w;
		case (pc)
			PC_IDLE:   w = '{op: OP_NOP,    cond: CND_IDLE,        target: PC_IDLE};
			PC_LD_SUM: w = '{op: OP_LD_SUM, cond: CND_SUM_ZERO,    target: PC_SILENT};
			PC_NORM:   w = '{op: OP_NORM,   cond: CND_NOT_NORMED,  target: PC_NORM};
			PC_MANT:   w = '{op: OP_MANT,   cond: CND_NEVER,       target: PC_IDLE};
			PC_SQUARE: w = '{op: OP_SQUARE, cond: CND_NEVER,       target: PC_IDLE};
			PC_FOLD:   w = '{op: OP_FOLD,   cond: CND_ITER_MORE,   target: PC_SQUARE};
			PC_SAVE:   w = '{op: OP_SAVE,   cond: CND_SECOND_PASS, target: PC_DIFF};
			PC_LD_CNT: w = '{op: OP_LD_CNT, cond: CND_ALWAYS,      target: PC_NORM};
			PC_DIFF:   w = '{op: OP_DIFF,   cond: CND_NEVER,       target: PC_IDLE};
			PC_MUL:    w = '{op: OP_MUL,    cond: CND_NEVER,       target: PC_IDLE};
			PC_ABS:    w = '{op: OP_ABS,    cond: CND_NEVER,       target: PC_IDLE};
			PC_ROUND:  w = '{op: OP_ROUND,  cond: CND_ALWAYS,      target: PC_PUSH};
			PC_SILENT: w = '{op: OP_SILENT, cond: CND_NEVER,       target: PC_IDLE};
			PC_PUSH:   w = '{op: OP_PUSH,   cond: CND_OUT_FREE,    target: PC_IDLE};
			PC_WAIT:   w = '{op: OP_NOP,    cond: CND_ALWAYS,      target: PC_PUSH};
			default:   w = '{op: OP_NOP,    cond: CND_ALWAYS,      target: PC_IDLE};
		endcase
		return w;
	endfunction

endpackage

// File: rtl/core/frdb_seq.sv
// ----------------------------------------------------------------------------
// Frame RMS level meter sequencer
// Program counter over the microcode table, with conditional jumps on the
// datapath and handshake flags.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "frame_rms_db_level_meter_unit_defines.svh"

module frdb_seq (
	input  logic                clk,
	input  logic                arst_n,
	input  frdb_pkg::seq_stat_t stat,
	output frdb_pkg::ctrl_t     ctrl
);
	import frdb_pkg::*;

	logic [PC_W-1:0] pc_q;
	logic            take;

	// Fetch the control word of the current step.
	assign ctrl = ucode_rom(pc_q);

	// Evaluate the jump condition of this step.
	always_comb begin
		case (ctrl.cond)
			CND_NEVER:       take = 1'b0;
			CND_ALWAYS:      take = 1'b1;
			CND_IDLE:        take = !stat.go;
			CND_SUM_ZERO:    take = stat.dp.sum_zero;
			CND_NOT_NORMED:  take = !stat.dp.top_set;
			CND_ITER_MORE:   take = stat.dp.iter_more;
			CND_SECOND_PASS: take = stat.dp.second_pass;
			CND_OUT_FREE:    take = !stat.out_full;
			default:         take = 1'b0;
		endcase
	end

	// Step counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= PC_IDLE;
		end else begin
			pc_q <= take ? ctrl.target : pc_q + PC_W'(1);
		end
	end

	// The program only runs while a frame result is owed.
	`FRDB_ASSERT_IMPL(a_run_needs_go, clk, arst_n, (pc_q != PC_IDLE), stat.go, "sequencer running without a frame")
	// The counter never leaves the program.
	`FRDB_ASSERT_ALWAYS(a_pc_in_program, clk, arst_n, (pc_q <= PC_WAIT), "sequencer left the program")

endmodule

// File: rtl/core/frdb_dp.sv
// ----------------------------------------------------------------------------
// Frame RMS level meter datapath
// Normalizer, squaring log2 unit, difference, scaling multiplier and rounding,
// each step selected by the control word of the sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module frdb_dp #(
	parameter int SUM_W = 41,
	parameter int CNT_W = 11
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  frdb_pkg::ctrl_t                       ctrl,
	input  logic [SUM_W-1:0]                      sum,
	input  logic [CNT_W-1:0]                      cnt,
	output frdb_pkg::dp_stat_t                    stat,
	output logic signed [frdb_pkg::LEVEL_W-1:0]   level
);
	import frdb_pkg::*;

	localparam int NORM_W = (SUM_W > MANT_W) ? SUM_W : MANT_W;
	localparam int EXP_W  = $clog2(NORM_W);
	localparam int LOG_W  = EXP_W + LOG_FRAC_W;
	localparam int DIFF_W = LOG_W + 1;
	localparam int PROD_W = DIFF_W + K_W;

	// Working registers.
	logic [NORM_W-1:0]             norm_q;
	logic [EXP_W-1:0]              exp_q;
	logic [MANT_W-1:0]             mant_q;
	logic [SQ_W-1:0]               sq_q;
	logic [LOG_FRAC_W-1:0]         frac_q;
	logic [ITER_W-1:0]             iter_q;
	logic                          pass_q;
	logic [LOG_W-1:0]              lsum_q;
	logic signed [DIFF_W-1:0]      diff_q;
	logic signed [PROD_W-1:0]      p_q;
	logic [PROD_W-1:0]             mag_q;
	logic                          neg_q;
	logic signed [LEVEL_W-1:0]     level_q;

	// Combinational results feeding the registers.
	logic [SQ_W-1:0]               sq_full;
	logic signed [DIFF_W-1:0]      diff_full;
	logic signed [PROD_W-1:0]      mul_full;
	logic                          p_neg;
	logic [PROD_W-1:0]             p_mag;
	logic [PROD_W-1:0]             rnd_sum;
	logic [LEVEL_W-1:0]            rnd;
	logic [LEVEL_W-1:0]            level_next;

	// Square of the Q1.31 mantissa.
	assign sq_full = mant_q * mant_q;

	// Log2 of the sum minus log2 of the count.
	assign diff_full = $signed({1'b0, lsum_q}) - $signed({1'b0, exp_q, frac_q});

	// Scale to 1/256 dB with 40 fraction bits.
	assign mul_full = diff_q * DB_SCALE_K;

	// Magnitude of the scaled product.
	assign p_neg = p_q[PROD_W-1];
	assign p_mag = p_neg ? (~$unsigned(p_q) + PROD_W'(1)) : $unsigned(p_q);

	// Round the magnitude half away from zero, then restore the sign.
	assign rnd_sum    = mag_q + (PROD_W'(1) << (ROUND_SHIFT - 1));
	assign rnd        = rnd_sum[ROUND_SHIFT +: LEVEL_W];
	assign level_next = neg_q ? (~rnd + LEVEL_W'(1)) : rnd;

	// Loop control: fraction bit counter and log2 pass flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iter_q <= '0;
			pass_q <= 1'b0;
		end else begin
			case (ctrl.op)
				OP_LD_SUM: pass_q <= 1'b0;
				OP_SAVE:   pass_q <= 1'b1;
				OP_MANT:   iter_q <= ITER_LAST;
				OP_FOLD: begin
					if (iter_q != '0) begin
						iter_q <= iter_q - ITER_W'(1);
					end
				end
				default: ;
			endcase
		end
	end

	// Arithmetic registers.
	always_ff @(posedge clk) begin
		case (ctrl.op)
			OP_LD_SUM: begin
				norm_q <= NORM_W'(sum);
				exp_q  <= EXP_W'(NORM_W - 1);
			end
			OP_LD_CNT: begin
				norm_q <= NORM_W'(cnt);
				exp_q  <= EXP_W'(NORM_W - 1);
			end
			OP_NORM: begin
				// One bit of the leading-zero search per step.
				if (!norm_q[NORM_W-1]) begin
					norm_q <= norm_q << 1;
					exp_q  <= exp_q - EXP_W'(1);
				end
			end
			OP_MANT: begin
				mant_q <= norm_q[NORM_W-1 -: MANT_W];
				frac_q <= '0;
			end
			OP_SQUARE: sq_q <= sq_full;
			OP_FOLD: begin
				// A square that reaches two gives a one bit and is halved.
				if (sq_q[SQ_W-1]) begin
					mant_q <= sq_q[SQ_W-1 -: MANT_W];
					frac_q <= {frac_q[LOG_FRAC_W-2:0], 1'b1};
				end else begin
					mant_q <= sq_q[SQ_W-2 -: MANT_W];
					frac_q <= {frac_q[LOG_FRAC_W-2:0], 1'b0};
				end
			end
			OP_SAVE: begin
				if (!pass_q) begin
					lsum_q <= {exp_q, frac_q};
				end
			end
			OP_DIFF:   diff_q  <= diff_full;
			OP_MUL:    p_q     <= mul_full;
			OP_ABS: begin
				mag_q <= p_mag;
				neg_q <= p_neg;
			end
			OP_ROUND:  level_q <= $signed(level_next);
			OP_SILENT: level_q <= LEVEL_SILENT;
			default: ;
		endcase
	end

	// Status for the sequencer.
	assign stat.sum_zero    = (sum == '0);
	assign stat.top_set     = norm_q[NORM_W-1];
	assign stat.iter_more   = (iter_q != '0);
	assign stat.second_pass = pass_q;

	assign level = level_q;

endmodule

// File: rtl/core/frame_rms_db_level_meter_unit.sv
// ----------------------------------------------------------------------------
// Frame RMS level meter
// Accumulates the squares of 16-bit samples over a frame and reports the
// frame RMS level in units of 1/256 dB when the last sample arrives.
// ----------------------------------------------------------------------------
// Samples are taken one per cycle while a frame is being collected; the sum of
// squares and the sample count update in the cycle of each transaction. The
// transaction marked with tlast closes the frame, and from then on s_tready is
// low while a microcoded sequencer works out 10*log10(sum/count): two passes of
// a bit-serial log2 (one leading-zero shift per cycle, then 24 square-and-fold
// rounds through one 32x32 multiplier), followed by the difference, the dB
// scaling multiply and the rounding. There is one leading-zero shift per
// leading zero of the sum and of the count in a 41-bit word for MAX_FRAME of
// 1024; an all-zero frame skips the log2 and gives -100 dB. Input resumes
// as soon as the result sits in the output register, even if the downstream
// side has not yet taken it. Samples beyond MAX_FRAME in one frame are
// ignored, but the marked sample still closes the frame.
`timescale 1ns / 1ps
`include "frame_rms_db_level_meter_unit_defines.svh"

module frame_rms_db_level_meter_unit #(
	parameter int MAX_FRAME = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,    // [15:0] sample
	input  logic        s_tlast,    // last_sample
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata     // [15:0] level_db
);
	import frdb_pkg::*;

	localparam int CNT_W = $clog2(MAX_FRAME + 1);
	localparam int SUM_W = 2 * SAMPLE_W - 1 + $clog2(MAX_FRAME);

	logic signed [SAMPLE_W-1:0]   sample;
	logic signed [2*SAMPLE_W-1:0] samp_sq;
	logic                         keep;
	logic                         accept;
	logic [SUM_W-1:0]             sum_q;
	logic [CNT_W-1:0]             cnt_q;
	logic [SUM_W-1:0]             sum_next;
	logic [CNT_W-1:0]             cnt_next;
	logic [SUM_W-1:0]             snap_sum_q;
	logic [CNT_W-1:0]             snap_cnt_q;
	logic                         go_q;
	logic                         out_valid_q;
	logic [LEVEL_W-1:0]           out_data_q;
	logic                         out_full;
	logic                         push;
	ctrl_t                        ctrl;
	dp_stat_t                     dp_stat;
	seq_stat_t                    seq_stat;
	logic signed [LEVEL_W-1:0]    level;

	// Input side: take samples unless a frame result is still owed.
	assign s_tready = !go_q;
	assign accept   = s_tvalid && s_tready;

	// Square and accumulate while the frame has room.
	assign sample   = $signed(s_tdata[SAMPLE_W-1:0]);
	assign samp_sq  = sample * sample;
	assign keep     = (cnt_q < CNT_W'(MAX_FRAME));
	assign sum_next = keep ? (sum_q + SUM_W'($unsigned(samp_sq))) : sum_q;
	assign cnt_next = keep ? (cnt_q + CNT_W'(1)) : cnt_q;

	// Output register handoff.
	assign out_full = out_valid_q && !m_tready;
	assign push     = (ctrl.op == OP_PUSH) && !out_full;

	// Accumulator, frame hold-off and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q       <= '0;
			cnt_q       <= '0;
			go_q        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				if (s_tlast) begin
					sum_q <= '0;
					cnt_q <= '0;
					go_q  <= 1'b1;
				end else begin
					sum_q <= sum_next;
					cnt_q <= cnt_next;
				end
			end
			if (push) begin
				go_q        <= 1'b0;
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Frame totals held for the sequencer, and the result register.
	always_ff @(posedge clk) begin
		if (accept && s_tlast) begin
			snap_sum_q <= sum_next;
			snap_cnt_q <= cnt_next;
		end
		if (push) begin
			out_data_q <= $unsigned(level);
		end
	end

	assign seq_stat.go       = go_q;
	assign seq_stat.out_full = out_full;
	assign seq_stat.dp       = dp_stat;

	frdb_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (seq_stat),
		.ctrl   (ctrl)
	);

	frdb_dp #(
		.SUM_W (SUM_W),
		.CNT_W (CNT_W)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ctrl),
		.sum    (snap_sum_q),
		.cnt    (snap_cnt_q),
		.stat   (dp_stat),
		.level  (level)
	);

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	// The sample count never passes the frame limit.
	`FRDB_ASSERT_ALWAYS(a_cnt_bound, clk, arst_n, (cnt_q <= CNT_W'(MAX_FRAME)), "sample count beyond frame limit")
	// A pushed result appears on the output in the next cycle.
	`FRDB_ASSERT_NEXT(a_push_shows, clk, arst_n, push, (m_tvalid && (m_tdata == $unsigned($past(level)))), "pushed level not presented")

endmodule
